// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASRT_CHK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// checked at every edge, reset included
`define ASRT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/core/dtmr_pkg.sv =====
// ----------------------------------------------------------------------------
// dtmr_pkg
// Shared types, constants and codes of the disparity reprojection block.
// ----------------------------------------------------------------------------
package dtmr_pkg;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int SIZE_W    = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;

    localparam logic [CFG_W-1:0] ROW0_RST = 64'h0000_0000_0000_0100;
    localparam logic [CFG_W-1:0] ROW1_RST = 64'h0000_0000_0100_0000;
    localparam logic [CFG_W-1:0] ROW2_RST = 64'h0000_0100_0000_0000;
    localparam logic [CFG_W-1:0] ROW3_RST = 64'h0100_0000_0000_0000;
    localparam logic [SIZE_W-1:0] SIZE_RST = 9'd256;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int COEF_W = 16;
    localparam int PROD_W = 33;
    localparam int ACC_W  = 34;
    localparam int NUM_W  = 40;
    localparam int DEN_W  = 32;
    localparam int IDX_W  = 17;

    localparam logic signed [15:0] DISP_LIMIT = -16'sd15984;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_TRI   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_DRAIN, S_EVAL, S_DIV_GO, S_DIV_WAIT,
        S_COMMIT, S_EMIT_PT, S_EMIT_T1, S_EMIT_T2
    } t_state;

    typedef enum logic [1:0] {TERM_X, TERM_Y, TERM_D} t_term;

    typedef enum logic [2:0] {OP_X, OP_Y, OP_Z, OP_U, OP_V} t_div_op;

    typedef enum logic [1:0] {EM_NONE, EM_PT, EM_T1, EM_T2} t_emit;

    typedef struct packed {
        logic       accept;
        logic       mac_issue;
        logic [1:0] mac_row;
        t_term      mac_term;
        logic       div_start;
        logic       div_store;
        t_div_op    op;
        logic       commit;
        t_emit      emit;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic in_frame;
        logic make_point;
        logic div_done;
        logic tri1_ok;
        logic tri2_ok;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/dtmr_div.sv =====
// ----------------------------------------------------------------------------
// dtmr_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtmr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dtmr_pkg::NUM_W-1:0] i_num,
    input  logic [dtmr_pkg::DEN_W-1:0] i_den,
    output logic                       o_done,
    output logic [dtmr_pkg::NUM_W-1:0] o_quo
);
    import dtmr_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W-1:0] n_rem;
    logic [NUM_W-1:0] n_quo;

    always_comb begin
        rem_sh = {r_rem, r_quo[NUM_W-1]};
        if (rem_sh >= {1'b0, r_den}) begin
            n_rem = DEN_W'(rem_sh - {1'b0, r_den});
            n_quo = {r_quo[NUM_W-2:0], 1'b1};
        end else begin
            n_rem = rem_sh[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/core/dtmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtmr_ctrl
// Sequencer: accept, matrix products, divisions, state update, result beats.
// ----------------------------------------------------------------------------
module dtmr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dtmr_pkg::t_sts  i_sts,
    output dtmr_pkg::t_cmd  o_cmd
);
    import dtmr_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_row, n_row;
    t_term      r_term, n_term;
    t_div_op    r_op, n_op;
    t_div_op    op_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_term  <= TERM_X;
            r_op    <= OP_X;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_term  <= n_term;
            r_op    <= n_op;
        end
    end

    always_comb begin
        unique case (r_op)
            OP_X:    op_next = OP_Y;
            OP_Y:    op_next = OP_Z;
            OP_Z:    op_next = OP_U;
            OP_U:    op_next = OP_V;
            default: op_next = OP_X;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_term     = r_term;
        n_op       = r_op;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mac_row  = r_row;
        o_cmd.mac_term = r_term;
        o_cmd.op       = r_op;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_row  = '0;
                    n_term = TERM_X;
                    if (i_sts.in_frame) n_state = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                unique case (r_term)
                    TERM_X: n_term = TERM_Y;
                    TERM_Y: n_term = TERM_D;
                    default: begin
                        n_term = TERM_X;
                        if (r_row == 2'd3) n_state = S_DRAIN;
                        else n_row = r_row + 2'd1;
                    end
                endcase
            end
            S_DRAIN: n_state = S_EVAL;
            S_EVAL: begin
                n_op = OP_X;
                if (i_sts.make_point) n_state = S_DIV_GO;
                else n_state = S_COMMIT;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_op == OP_V) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_op    = op_next;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (i_sts.make_point) n_state = S_EMIT_PT;
                else n_state = S_IDLE;
            end
            S_EMIT_PT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = EM_PT;
                    o_cmd.last = !(i_sts.tri1_ok || i_sts.tri2_ok);
                    priority if (i_sts.tri1_ok) n_state = S_EMIT_T1;
                    else if (i_sts.tri2_ok) n_state = S_EMIT_T2;
                    else n_state = S_IDLE;
                end
            end
            S_EMIT_T1: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = EM_T1;
                    o_cmd.last = !i_sts.tri2_ok;
                    n_state = i_sts.tri2_ok ? S_EMIT_T2 : S_IDLE;
                end
            end
            S_EMIT_T2: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = EM_T2;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/dtmr_dp.sv =====
// ----------------------------------------------------------------------------
// dtmr_dp
// Datapath: configuration, shared multiplier, accumulators, divider operands,
// point index store and the output register.
// ----------------------------------------------------------------------------
module dtmr_dp #(
    parameter int MAX_WIDTH  = dtmr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dtmr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dtmr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dtmr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [7:0]                     i_column,
    input  logic [7:0]                     i_row,
    input  logic signed [15:0]             i_disparity,
    input  logic                           i_outside_rectified,
    input  dtmr_pkg::t_cmd                 i_cmd,
    output dtmr_pkg::t_sts                 o_sts,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_kind,
    output logic signed [31:0]             o_pos_x,
    output logic signed [31:0]             o_pos_y,
    output logic signed [31:0]             o_pos_z,
    output logic [16:0]                    o_tex_u,
    output logic [16:0]                    o_tex_v,
    output logic [15:0]                    o_point_number,
    output logic [15:0]                    o_vertex_a,
    output logic [15:0]                    o_vertex_b,
    output logic [15:0]                    o_vertex_c,
    output logic                           o_last
);
    import dtmr_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_HEIGHT);

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        if (v > 42'sd2147483647) return 32'sh7fff_ffff;
        if (v < -42'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // configuration
    logic [CFG_W-1:0]  r_mrow [4];
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic [WW-1:0]     w;
    logic [HW-1:0]     h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mrow[0] <= ROW0_RST;
            r_mrow[1] <= ROW1_RST;
            r_mrow[2] <= ROW2_RST;
            r_mrow[3] <= ROW3_RST;
            r_width   <= SIZE_RST;
            r_height  <= SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW0:   r_mrow[0] <= i_cfg_data;
                CFG_ROW1:   r_mrow[1] <= i_cfg_data;
                CFG_ROW2:   r_mrow[2] <= i_cfg_data;
                CFG_ROW3:   r_mrow[3] <= i_cfg_data;
                CFG_WIDTH:  r_width   <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: r_height  <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) w = WW'(1);
        else if (32'(r_width) > 32'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
        else w = WW'(r_width);
        if (r_height == '0) h = HW'(1);
        else if (32'(r_height) > 32'(MAX_HEIGHT)) h = HW'(MAX_HEIGHT);
        else h = HW'(r_height);
    end

    // captured pixel
    logic [7:0]         r_x;
    logic [7:0]         r_y;
    logic signed [15:0] r_d;
    logic [AW-1:0]      r_ri;
    logic [AW-1:0]      ri_in;
    logic               in_frame;

    assign ri_in    = AW'(i_row);
    assign in_frame = (32'(i_column) < 32'(w)) && (32'(i_row) < 32'(h));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x  <= i_column;
            r_y  <= i_row;
            r_d  <= i_outside_rectified ? 16'sd0 : i_disparity;
            r_ri <= ri_in;
        end
    end

    // previous column point indices
    logic [IDX_W-1:0] mem [MAX_HEIGHT];
    logic [IDX_W-1:0] r_rd;
    logic [IDX_W-1:0] here;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) mem[r_ri] <= here;
        if (i_cmd.accept) r_rd <= mem[ri_in];
    end

    // shared multiplier and row accumulators
    logic signed [COEF_W-1:0] mul_a;
    logic signed [COEF_W-1:0] c3;
    logic signed [16:0]       mul_b;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pvalid;
    logic [1:0]               r_prow;
    t_term                    r_pterm;
    logic signed [ACC_W-1:0]  r_acc [4];
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_base;

    always_comb begin
        mul_a = r_mrow[i_cmd.mac_row][{i_cmd.mac_term, 4'b0000} +: COEF_W];
        c3    = r_mrow[r_prow][CFG_W-1 -: COEF_W];
        unique case (i_cmd.mac_term)
            TERM_X:  mul_b = signed'({9'b0, r_x});
            TERM_Y:  mul_b = signed'({9'b0, r_y});
            default: mul_b = {r_d[15], r_d};
        endcase
        prod_ext = ACC_W'(r_prod);
        if (r_pterm != TERM_D) prod_ext = prod_ext <<< 4;
        // first product of a row starts from the constant column
        acc_base = (r_pterm == TERM_X) ? (ACC_W'(c3) <<< 4) : r_acc[r_prow];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_cmd.mac_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_issue) begin
            r_prod  <= mul_a * mul_b;
            r_prow  <= i_cmd.mac_row;
            r_pterm <= i_cmd.mac_term;
        end
        if (r_pvalid) r_acc[r_prow] <= acc_base + prod_ext;
    end

    // point indices and counter
    logic [IDX_W-1:0] r_diag;
    logic [IDX_W-1:0] r_above;
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_in1;
    logic [IDX_W-1:0] r_in2;
    logic [IDX_W-1:0] r_in4;
    logic [IDX_W-1:0] r_here;
    logic             make_point;

    assign make_point = (r_d > DISP_LIMIT) && (r_acc[3] != '0) && !r_cnt[IDX_W-1];
    assign here       = make_point ? {1'b1, r_cnt[15:0]} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag  <= '0;
            r_above <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.accept && in_frame && i_column == 8'd0 && i_row == 8'd0)
                r_cnt <= '0;
            if (i_cmd.commit) begin
                r_diag  <= (r_x == 8'd0) ? '0 : r_rd;
                r_above <= here;
                r_cnt   <= r_cnt + IDX_W'(make_point);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_in1  <= (r_y == 8'd0) ? '0 : r_diag;
            r_in2  <= (r_y == 8'd0) ? '0 : r_above;
            r_in4  <= (r_x == 8'd0) ? '0 : r_rd;
            r_here <= here;
        end
    end

    // divider operands and results
    logic signed [ACC_W-1:0] acc_sel;
    logic [ACC_W-1:0]        mag_sel;
    logic [ACC_W-1:0]        mag_w;
    logic [HW-1:0]           hmy;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_neg;
    logic                    r_neg;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quo;
    logic signed [NUM_W:0]   q_s;
    logic signed [41:0]      q_y;
    logic signed [31:0]      r_px;
    logic signed [31:0]      r_py;
    logic signed [31:0]      r_pz;
    logic [16:0]             r_tu;
    logic [16:0]             r_tv;
    logic [16:0]             tex_q;

    always_comb begin
        unique case (i_cmd.op)
            OP_X:    acc_sel = r_acc[0];
            OP_Y:    acc_sel = r_acc[1];
            default: acc_sel = r_acc[2];
        endcase
        mag_sel = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
        mag_w   = r_acc[3][ACC_W-1] ? ACC_W'(-r_acc[3]) : ACC_W'(r_acc[3]);
        hmy     = h - HW'(r_y);
        unique case (i_cmd.op)
            OP_U: begin
                div_num = NUM_W'({r_x, 16'b0});
                div_den = DEN_W'(w);
                div_neg = 1'b0;
            end
            OP_V: begin
                div_num = NUM_W'({hmy, 16'b0});
                div_den = DEN_W'(h);
                div_neg = 1'b0;
            end
            default: begin
                div_num = {mag_sel[DEN_W-1:0], 8'b0};
                div_den = mag_w[DEN_W-1:0];
                div_neg = acc_sel[ACC_W-1] ^ r_acc[3][ACC_W-1];
            end
        endcase
        q_s   = r_neg ? -signed'({1'b0, div_quo}) : signed'({1'b0, div_quo});
        q_y   = (signed'(42'(h)) <<< 8) - 42'(q_s);
        tex_q = (div_quo > NUM_W'(65536)) ? 17'd65536 : div_quo[16:0];
    end

    dtmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) r_neg <= div_neg;
        if (i_cmd.div_store) begin
            unique case (i_cmd.op)
                OP_X:    r_px <= sat32(42'(q_s));
                OP_Y:    r_py <= sat32(q_y);
                OP_Z:    r_pz <= sat32(42'(q_s));
                OP_U:    r_tu <= tex_q;
                default: r_tv <= tex_q;
            endcase
        end
    end

    // output register
    logic r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit != EM_NONE) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.emit)
            EM_PT: begin
                o_kind         <= KIND_POINT;
                o_pos_x        <= r_px;
                o_pos_y        <= r_py;
                o_pos_z        <= r_pz;
                o_tex_u        <= r_tu;
                o_tex_v        <= r_tv;
                o_point_number <= r_here[15:0];
                o_vertex_a     <= '0;
                o_vertex_b     <= '0;
                o_vertex_c     <= '0;
                o_last         <= i_cmd.last;
            end
            EM_T1, EM_T2: begin
                o_kind         <= KIND_TRI;
                o_pos_x        <= '0;
                o_pos_y        <= '0;
                o_pos_z        <= '0;
                o_tex_u        <= '0;
                o_tex_v        <= '0;
                o_point_number <= '0;
                o_vertex_a     <= r_in1[15:0];
                o_vertex_b     <= (i_cmd.emit == EM_T1) ? r_in2[15:0] : r_here[15:0];
                o_vertex_c     <= (i_cmd.emit == EM_T1) ? r_here[15:0] : r_in4[15:0];
                o_last         <= i_cmd.last;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;

    always_comb begin
        o_sts.in_frame   = in_frame;
        o_sts.make_point = make_point;
        o_sts.div_done   = div_done;
        o_sts.tri1_ok    = r_in1[IDX_W-1] && r_in2[IDX_W-1];
        o_sts.tri2_ok    = r_in1[IDX_W-1] && r_in4[IDX_W-1];
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

endmodule

// ===== rtl/core/disparity_to_mesh_reprojection_top.sv =====
// ----------------------------------------------------------------------------
// disparity_to_mesh_reprojection_top
// Reprojects column-major disparity pixels through a 4x4 matrix into numbered
// points and emits up to two mesh triangles per pixel.
//
//   channel   handshake                   beat contents
//   input     i_in_valid / o_in_ready     column, row, disparity, mask flag
//   output    o_out_valid / i_out_ready   point or triangle record, last
//   config    i_cfg_we                    index 0..5, 64-bit data
//
// a pixel outside the frame is taken in without leaving the idle state; a
// pixel that makes no point runs the matrix products and the state update; a
// point adds five divisions through the one shared divider and its beats
// reset is synchronous; the index store needs no clearing pass
// a stalled output holds the last beat while the next pixel is taken in
// ----------------------------------------------------------------------------
module disparity_to_mesh_reprojection_top #(
    parameter int MAX_WIDTH  = dtmr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dtmr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dtmr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dtmr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_column,
    input  logic [7:0]                     i_row,
    input  logic signed [15:0]             i_disparity,
    input  logic                           i_outside_rectified,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_kind,
    output logic signed [31:0]             o_pos_x,
    output logic signed [31:0]             o_pos_y,
    output logic signed [31:0]             o_pos_z,
    output logic [16:0]                    o_tex_u,
    output logic [16:0]                    o_tex_v,
    output logic [15:0]                    o_point_number,
    output logic [15:0]                    o_vertex_a,
    output logic [15:0]                    o_vertex_b,
    output logic [15:0]                    o_vertex_c,
    output logic                           o_last
);
    import dtmr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    dtmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dtmr_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_column            (i_column),
        .i_row               (i_row),
        .i_disparity         (i_disparity),
        .i_outside_rectified (i_outside_rectified),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_kind              (o_kind),
        .o_pos_x             (o_pos_x),
        .o_pos_y             (o_pos_y),
        .o_pos_z             (o_pos_z),
        .o_tex_u             (o_tex_u),
        .o_tex_v             (o_tex_v),
        .o_point_number      (o_point_number),
        .o_vertex_a          (o_vertex_a),
        .o_vertex_b          (o_vertex_b),
        .o_vertex_c          (o_vertex_c),
        .o_last              (o_last)
    );

endmodule

// ===== rtl/core/dtmr_chk.sv =====
// ----------------------------------------------------------------------------
// dtmr_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtmr_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_kind,
    input logic signed [31:0] o_pos_x,
    input logic [16:0]        o_tex_u,
    input logic [16:0]        o_tex_v,
    input logic [15:0]        o_point_number,
    input logic [15:0]        o_vertex_a,
    input logic [15:0]        o_vertex_b,
    input logic [15:0]        o_vertex_c,
    input logic               o_last
);

    `ASRT_ANY(a_rst_idle, i_clk, !i_rst_n |=> !o_out_valid)
    `ASRT_CHK(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pos_x) && $stable(o_last))
    `ASRT_CHK(a_pt_novtx, i_clk, i_rst_n, o_out_valid && !o_kind |-> o_vertex_a == 16'd0 && o_vertex_b == 16'd0 && o_vertex_c == 16'd0)
    `ASRT_CHK(a_tri_nopos, i_clk, i_rst_n, o_out_valid && o_kind |-> o_pos_x == 32'sd0 && o_tex_u == 17'd0 && o_point_number == 16'd0)
    `ASRT_CHK(a_tex_range, i_clk, i_rst_n, o_out_valid |-> o_tex_u <= 17'd65536 && o_tex_v <= 17'd65536)

endmodule

bind disparity_to_mesh_reprojection_top dtmr_chk u_dtmr_chk (.*);
